// ===== sv/hcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the driver-word function for the H-bridge
// command parser. No dependencies.
package hcp_pkg;

   localparam int BOARDS = 4;
   localparam int CHIPS  = BOARDS * 3;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int FIELD_W = 3;
   localparam int CHIP_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam int BOARD_W = $clog2(BOARDS + 1);

   localparam int LATCH_BIT = 6;
   localparam int START_BIT = 7;

   // position of a data byte within its board
   localparam logic [1:0] SEQ_FIRST = 2'd0;
   localparam logic [1:0] SEQ_MID   = 2'd1;
   localparam logic [1:0] SEQ_LAST  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ERR
   } ctrl_state_type;

   typedef struct packed {
      logic store_byte;
      logic load_word;
      logic load_err;
      logic init_chip;
      logic dec_chip;
   } cmd_type;

   typedef struct packed {
      logic is_latch;
      logic overflow;
      logic slot_free;
      logic chip_zero;
   } status_type;

   // zeros[15:13], enable pairs[12:7], direction pairs[6:1], zero bit 0
   function automatic logic [WORD_W-1:0] chip_word(input logic [FIELD_W-1:0] en,
                                                   input logic [FIELD_W-1:0] dir);
      logic [5:0] en_pairs;
      logic [5:0] dir_pairs;
      en_pairs  = '0;
      dir_pairs = '0;
      for (int j = 0; j < FIELD_W; j++) begin
         en_pairs[2*j]    = en[j];
         en_pairs[2*j+1]  = en[j];
         dir_pairs[2*j]   = dir[j];
         dir_pairs[2*j+1] = ~dir[j];
      end
      return {3'b000, en_pairs, dir_pairs, 1'b0};
   endfunction

endpackage

// ===== sv/hcp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the H-bridge command parser: per-chip bit store, byte
// counters, chip walker and result register. Uses hcp_pkg.
module hcp_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hcp_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                        rsp_ready,
   input  hcp_pkg::cmd_type            cmd,
   output hcp_pkg::status_type         status,
   output logic                        rsp_valid,
   output logic [hcp_pkg::WORD_W-1:0]  rsp_spi_word,
   output logic                        rsp_last_word,
   output logic                        rsp_overflow_error
);

   logic [hcp_pkg::FIELD_W-1:0] en_ff  [hcp_pkg::CHIPS];
   logic [hcp_pkg::FIELD_W-1:0] en_in  [hcp_pkg::CHIPS];
   logic [hcp_pkg::FIELD_W-1:0] dir_ff [hcp_pkg::CHIPS];
   logic [hcp_pkg::FIELD_W-1:0] dir_in [hcp_pkg::CHIPS];

   logic                         started_ff, started_in;
   logic [hcp_pkg::BOARD_W-1:0]  board_ff, board_in;
   logic [1:0]                   seq_ff, seq_in;
   logic [hcp_pkg::CHIP_W-1:0]   chip_ff, chip_in;

   logic                         valid_ff, valid_in;
   logic [hcp_pkg::WORD_W-1:0]   word_ff, word_in;
   logic                         last_ff, last_in;
   logic                         ovf_ff, ovf_in;

   logic                         is_start;
   logic                         started_eff;
   logic [hcp_pkg::BOARD_W-1:0]  board_eff;
   logic [1:0]                   seq_eff;
   logic                         overflow;
   logic                         do_write;
   logic [hcp_pkg::FIELD_W-1:0]  lo_field;
   logic [hcp_pkg::FIELD_W-1:0]  hi_field;
   logic                         slot_free;

   assign lo_field    = req_rx_byte[2:0];
   assign hi_field    = req_rx_byte[5:3];
   assign is_start    = req_rx_byte[hcp_pkg::START_BIT];
   assign started_eff = started_ff | is_start;
   assign board_eff   = is_start ? '0 : board_ff;
   assign seq_eff     = is_start ? hcp_pkg::SEQ_FIRST : seq_ff;
   assign overflow    = started_eff && (board_eff >= hcp_pkg::BOARD_W'(hcp_pkg::BOARDS));
   assign do_write    = cmd.store_byte && started_eff && !overflow;
   assign slot_free   = !valid_ff || rsp_ready;

   assign status.is_latch  = req_rx_byte[hcp_pkg::LATCH_BIT];
   assign status.overflow  = overflow;
   assign status.slot_free = slot_free;
   assign status.chip_zero = (chip_ff == '0);

   // store the two fields of a data byte into the addressed board
   always_comb begin
      en_in  = en_ff;
      dir_in = dir_ff;
      if (do_write) begin
         for (int b = 0; b < hcp_pkg::BOARDS; b++) begin
            if (board_eff == hcp_pkg::BOARD_W'(b)) begin
               case (seq_eff)
                  hcp_pkg::SEQ_FIRST: begin
                     en_in[b*3]   = lo_field;
                     en_in[b*3+1] = hi_field;
                  end
                  hcp_pkg::SEQ_MID: begin
                     en_in[b*3+2] = lo_field;
                     dir_in[b*3]  = hi_field;
                  end
                  default: begin
                     dir_in[b*3+1] = lo_field;
                     dir_in[b*3+2] = hi_field;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      started_in = started_ff;
      board_in   = board_ff;
      seq_in     = seq_ff;
      if (cmd.store_byte && is_start) begin
         started_in = 1'b1;
      end
      if (do_write) begin
         if (seq_eff == hcp_pkg::SEQ_LAST) begin
            seq_in   = hcp_pkg::SEQ_FIRST;
            board_in = board_eff + 1'b1;
         end else begin
            seq_in   = seq_eff + 1'b1;
            board_in = board_eff;
         end
      end
   end

   always_comb begin
      chip_in = chip_ff;
      if (cmd.init_chip) begin
         chip_in = hcp_pkg::CHIP_W'(hcp_pkg::CHIPS - 1);
      end else if (cmd.dec_chip) begin
         chip_in = chip_ff - 1'b1;
      end
   end

   // result register: load a word or an error, drop once taken
   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;
      if (cmd.load_word) begin
         valid_in = 1'b1;
         word_in  = hcp_pkg::chip_word(en_ff[chip_ff], dir_ff[chip_ff]);
         last_in  = (chip_ff == '0);
         ovf_in   = 1'b0;
      end else if (cmd.load_err) begin
         valid_in = 1'b1;
         word_in  = '0;
         last_in  = 1'b1;
         ovf_in   = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hcp_pkg::CHIPS; i++) begin
            en_ff[i]  <= '0;
            dir_ff[i] <= '0;
         end
         started_ff <= 1'b0;
         board_ff   <= '0;
         seq_ff     <= hcp_pkg::SEQ_FIRST;
         chip_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         en_ff      <= en_in;
         dir_ff     <= dir_in;
         started_ff <= started_in;
         board_ff   <= board_in;
         seq_ff     <= seq_in;
         chip_ff    <= chip_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_spi_word       = word_ff;
   assign rsp_last_word      = last_ff;
   assign rsp_overflow_error = ovf_ff;

`ifndef SYNTHESIS
   a_load_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_word && cmd.load_err))
      else $error("word and error loaded together");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_word || cmd.load_err) |-> slot_free)
      else $error("result register overwritten before it was taken");

   a_board_range: assert property (@(posedge clock) disable iff (reset)
      (board_ff <= hcp_pkg::BOARD_W'(hcp_pkg::BOARDS)) && (seq_ff != 2'd3))
      else $error("byte counter out of range");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ovf_ff) |-> (last_ff && (word_ff == '0)))
      else $error("malformed overflow result");
`endif

endmodule

// ===== sv/hcp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the H-bridge command parser: takes bytes and sequences the
// latch walk and overflow result. Uses hcp_pkg.
module hcp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hcp_pkg::status_type   status,
   output hcp_pkg::cmd_type      cmd
);

   hcp_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.is_latch) begin
                  state_in = hcp_pkg::ST_WALK;
               end else if (status.overflow) begin
                  state_in = hcp_pkg::ST_ERR;
               end
            end
         end
         hcp_pkg::ST_WALK: begin
            if (status.slot_free && status.chip_zero) begin
               state_in = hcp_pkg::ST_IDLE;
            end
         end
         hcp_pkg::ST_ERR: begin
            if (status.slot_free) begin
               state_in = hcp_pkg::ST_IDLE;
            end
         end
         default: state_in = hcp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         hcp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.init_chip  = status.is_latch;
               cmd.store_byte = !status.is_latch;
            end
         end
         hcp_pkg::ST_WALK: begin
            if (status.slot_free) begin
               cmd.load_word = 1'b1;
               cmd.dec_chip  = !status.chip_zero;
            end
         end
         hcp_pkg::ST_ERR: begin
            cmd.load_err = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/hbridge_command_parser_to_spi.sv =====
`timescale 1ns / 1ps
// Top level of the H-bridge command parser: joins hcp_ctrl and hcp_datapath.
// Uses hcp_pkg.
//
// Command bytes arrive on req_ (valid/ready), driver words leave on rsp_.
// A byte with bit 7 set restarts the byte count; each board then takes three
// data bytes carrying the enable and direction fields of its three chips.
// Data bytes seen before any start byte are dropped without a result.
// A data byte up to the last board is taken while idle and gives no result.
// A latch byte (bit 6) makes the block emit one 16-bit word per chip, last
// chip first, with rsp_last_word on the word of chip 0. The latch beat sets
// the chip walker to the last chip and enters ST_WALK, which loads the first
// word into the output register; the walk then moves one chip per cycle, and
// req_ready stays low until the walk is done. The walk advances only as the
// output register frees.
// A data byte past the last board gives one result with rsp_overflow_error
// and rsp_last_word set, loaded from ST_ERR once the output register is free.
// Reset clears all stored bits, the byte count and the started flag.
// While the receiver stalls the result holds in the output register; data
// bytes are still taken during that time if the block is idle.
module hbridge_command_parser_to_spi (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hcp_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hcp_pkg::WORD_W-1:0]  rsp_spi_word,
   output logic                        rsp_last_word,
   output logic                        rsp_overflow_error
);

   hcp_pkg::cmd_type    cmd;
   hcp_pkg::status_type status;

   hcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hcp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .rsp_ready          (rsp_ready),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_spi_word       (rsp_spi_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule
